@@ hdl/sorted_max_priority_queue_defines.svh @@
// ----------------------------------------------------------------------------
// sorted_max_priority_queue_defines
// Assertion macros shared by the checker of the priority queue.
// ----------------------------------------------------------------------------
`ifndef SORTED_MAX_PRIORITY_QUEUE_DEFINES_SVH
`define SORTED_MAX_PRIORITY_QUEUE_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define SMPQ_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SMPQ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/smpq_pkg.sv @@
// ----------------------------------------------------------------------------
// smpq_pkg
// Types and constants of the sorted max-priority queue.
// ----------------------------------------------------------------------------
package smpq_pkg;

    localparam int CAP_W = 5;
    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    localparam logic CMD_ENQ = 1'b0;
    localparam logic CMD_DEQ = 1'b1;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } smpq_status_t;

    // shift commands broadcast along the cell chain
    typedef struct packed {
        logic enq;
        logic deq;
    } smpq_op_t;

endpackage

@@ hdl/sorted_max_priority_queue.sv @@
// ----------------------------------------------------------------------------
// sorted_max_priority_queue
// Bounded max-priority queue kept as a sorted chain of cells, largest at the
// head, equal values leaving in arrival order.
// ----------------------------------------------------------------------------
//  channel   direction  handshake            payload
//  in        input      in_valid/in_ready    command, value
//  out       output     out_valid/out_ready  status, removed_value, head_value,
//                                            count
//  cfg       input      cfg_wr_en            cfg_wr_data (capacity)
//
//  One transfer per cycle while out is not stalled: every cell compares and
//  shifts in parallel, so an enqueue or dequeue completes in the cycle it is
//  accepted; its result is registered in the output register.
//  in_ready is high whenever the output register is empty or being drained, so
//  a stall on out holds in only while a result is waiting.
//  Reset empties the queue and sets capacity to 16; the cell values are not
//  cleared, slots beyond the count are never shown.
// ----------------------------------------------------------------------------
module sorted_max_priority_queue
    import smpq_pkg::*;
#(
    parameter int DEPTH       = 16,
    parameter int VALUE_WIDTH = 32,
    localparam int CNT_W      = $clog2(DEPTH + 1)
)
(
    input  logic                          clk,
    input  logic                          rst_n,

    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          command,
    input  logic signed [VALUE_WIDTH-1:0] value,

    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [1:0]                    status,
    output logic signed [VALUE_WIDTH-1:0] removed_value,
    output logic signed [VALUE_WIDTH-1:0] head_value,
    output logic [CNT_W-1:0]              count,

    input  logic                          cfg_wr_en,
    input  logic [CAP_W-1:0]              cfg_wr_data
);

    // width wide enough for both the count and the capacity register
    localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

    logic [CAP_W-1:0]              cap_reg;
    logic [CNT_W-1:0]              count_reg;
    logic [CNT_W-1:0]              count_next;

    logic                          out_valid_reg;
    smpq_status_t                  status_reg;
    smpq_status_t                  status_next;
    logic signed [VALUE_WIDTH-1:0] removed_reg;
    logic signed [VALUE_WIDTH-1:0] removed_next;
    logic signed [VALUE_WIDTH-1:0] head_reg;
    logic signed [VALUE_WIDTH-1:0] head_next;
    logic [CNT_W-1:0]              count_out_reg;

    logic                          xfer;
    logic                          full;
    logic                          empty;
    smpq_op_t                      op;

    logic                          gt   [DEPTH];
    logic signed [VALUE_WIDTH-1:0] cval [DEPTH];

    assign in_ready      = !out_valid_reg || out_ready;
    assign xfer          = in_valid && in_ready;
    assign out_valid     = out_valid_reg;
    assign status        = status_reg;
    assign removed_value = removed_reg;
    assign head_value    = head_reg;
    assign count         = count_out_reg;

    // limit is the smaller of capacity and the built depth
    assign full  = (CMP_W'(count_reg) >= CMP_W'(cap_reg))
                || (CMP_W'(count_reg) >= CMP_W'(DEPTH));
    assign empty = (count_reg == '0);

    assign op.enq = xfer && (command == CMD_ENQ) && !full;
    assign op.deq = xfer && (command == CMD_DEQ) && !empty;

    // ---- cell chain: slot 0 is the head ----
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic signed [VALUE_WIDTH-1:0] left_val;
        logic                          left_gt;
        logic signed [VALUE_WIDTH-1:0] right_val;

        if (i == 0)
        begin : g_head
            assign left_val = value;
            assign left_gt  = 1'b0;
        end
        else
        begin : g_body
            assign left_val = cval[i-1];
            assign left_gt  = gt[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_tail
            assign right_val = cval[i];
        end
        else
        begin : g_mid
            assign right_val = cval[i+1];
        end

        smpq_cell #(
            .W (VALUE_WIDTH)
        ) u_cell (
            .clk       (clk),
            .op        (op),
            .valid     (CNT_W'(i) < count_reg),
            .v         (value),
            .left_val  (left_val),
            .left_gt   (left_gt),
            .right_val (right_val),
            .gt        (gt[i]),
            .val       (cval[i])
        );
    end

    // ---- result of the step ----
    always_comb
    begin
        status_next  = ST_DONE;
        removed_next = '0;
        count_next   = count_reg;
        head_next    = cval[0];
        if (command == CMD_ENQ)
        begin
            if (full)
            begin
                status_next = ST_FULL;
            end
            else
            begin
                count_next = count_reg + 1'b1;
                if (gt[0])
                begin
                    head_next = value;
                end
            end
        end
        else
        begin
            if (empty)
            begin
                status_next = ST_EMPTY;
            end
            else
            begin
                removed_next = cval[0];
                count_next   = count_reg - 1'b1;
                head_next    = cval[1];
            end
        end
        if (count_next == '0)
        begin
            head_next = '0;
        end
    end

    // ---- control state ----
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg       <= CAP_RESET;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                cap_reg <= cfg_wr_data;
            end
            if (xfer)
            begin
                count_reg     <= count_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // ---- output payload ----
    always_ff @(posedge clk)
    begin
        if (xfer)
        begin
            status_reg    <= status_next;
            removed_reg   <= removed_next;
            head_reg      <= head_next;
            count_out_reg <= count_next;
        end
    end

endmodule

@@ hdl/smpq_cell.sv @@
// ----------------------------------------------------------------------------
// smpq_cell
// One slot of the sorted chain: holds a value, compares it with the incoming
// value and takes its own, the new or a neighbour's value each cycle.
// ----------------------------------------------------------------------------
module smpq_cell
    import smpq_pkg::*;
#(
    parameter int W = 32
)
(
    input  logic                clk,
    input  smpq_op_t            op,
    input  logic                valid,
    input  logic signed [W-1:0] v,
    input  logic signed [W-1:0] left_val,
    input  logic                left_gt,
    input  logic signed [W-1:0] right_val,
    output logic                gt,
    output logic signed [W-1:0] val
);

    logic signed [W-1:0] val_reg;
    logic signed [W-1:0] val_next;

    // empty slots count as smaller than anything; ties keep arrival order
    assign gt  = !valid || (v > val_reg);
    assign val = val_reg;

    always_comb
    begin
        val_next = val_reg;
        if (op.enq && gt)
        begin
            val_next = left_gt ? left_val : v;
        end
        else if (op.deq)
        begin
            val_next = right_val;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
    end

endmodule

@@ hdl/smpq_checker.sv @@
// ----------------------------------------------------------------------------
// smpq_checker
// Port-level checks on the priority queue, bound to the top level.
// ----------------------------------------------------------------------------
`include "sorted_max_priority_queue_defines.svh"

module smpq_checker
    import smpq_pkg::*;
#(
    parameter int DEPTH       = 16,
    parameter int VALUE_WIDTH = 32,
    parameter int CNT_W       = $clog2(DEPTH + 1)
)
(
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_ready,
    input logic                          out_valid,
    input logic                          out_ready,
    input logic [1:0]                    status,
    input logic signed [VALUE_WIDTH-1:0] removed_value,
    input logic signed [VALUE_WIDTH-1:0] head_value,
    input logic [CNT_W-1:0]              count
);

    `SMPQ_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(status) && $stable(count), "result dropped or changed while stalled")

    `SMPQ_ASSERT_NOW(a_count_bound, out_valid, count <= DEPTH, "count above depth")

    `SMPQ_ASSERT_NOW(a_empty_result, out_valid && status == ST_EMPTY, count == '0 && head_value == '0 && removed_value == '0, "empty result not blank")

    `SMPQ_ASSERT_NOW(a_refused_zero, out_valid && status != ST_DONE, removed_value == '0, "refused request reports a removed value")

    `SMPQ_ASSERT_NOW(a_backpressure, out_valid && !out_ready, !in_ready, "input taken while result waits")

endmodule

bind sorted_max_priority_queue smpq_checker #(
    .DEPTH       (DEPTH),
    .VALUE_WIDTH (VALUE_WIDTH),
    .CNT_W       (CNT_W)
) u_smpq_checker (.*);
